// ===== rtl/ddd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Date day difference package
// Shared widths, constants, calendar tables and codes for the date day
// difference pipeline.
// ----------------------------------------------------------------------------
package ddd_pkg;

  // Year field width; the design holds for 12 to 16 bits
  localparam int YEAR_BITS = 14;
  localparam int DAY_BITS = 5;
  localparam int MONTH_BITS = 4;

  // Stages of the serial day number pipeline
  localparam int STAGES = 4;

  // Serial day number: 365 * year plus leap days plus zero-based day of year
  localparam int SER_W = YEAR_BITS + 9;

  // Quotient of year / 100
  localparam int QUO_W = YEAR_BITS - 6;

  // Reciprocal of 100 rounded down; the estimate is short by at most one
  localparam int RECIP_SHIFT = YEAR_BITS + 7;
  localparam int RECIP_W = YEAR_BITS + 1;
  localparam int PROD_W = YEAR_BITS + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'((1 << RECIP_SHIFT) / 100);

  localparam int LEAPS_W = YEAR_BITS - 1;
  localparam int OFFS_W = 9;
  localparam int REM_W = 8;

  localparam int DAYS_YEAR = 365;
  localparam int CENTURY = 100;

  localparam int COUNT_W = 22;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam int DIFF_W = (SER_W > COUNT_W) ? SER_W : COUNT_W;

  localparam logic [MONTH_BITS-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_BITS-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_BITS-1:0] MONTH_DEC = 4'd12;

  typedef enum logic [1:0] {
    ORD_EQUAL         = 2'd0,
    ORD_FIRST_LATER   = 2'd1,
    ORD_FIRST_EARLIER = 2'd2
  } order_t;

  // Length of a month; codes outside 1..12 are screened out separately
  function automatic logic [DAY_BITS-1:0] month_len(input logic [MONTH_BITS-1:0] m,
                                                    input logic leap);
    logic [DAY_BITS-1:0] len;
    case (m)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // Days in the year before the first of a month, common year
  function automatic logic [OFFS_W-1:0] days_before(input logic [MONTH_BITS-1:0] m);
    logic [OFFS_W-1:0] n;
    case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ddd_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Date day difference channels
// Valid/ready channels for date pair words and day count result words.
// ----------------------------------------------------------------------------
interface ddd_in_if;
  import ddd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [DAY_BITS-1:0]   day_first;
  logic [MONTH_BITS-1:0] month_first;
  logic [YEAR_BITS-1:0]  year_first;
  logic [DAY_BITS-1:0]   day_second;
  logic [MONTH_BITS-1:0] month_second;
  logic [YEAR_BITS-1:0]  year_second;

  modport source (
    output valid, day_first, month_first, year_first,
    output day_second, month_second, year_second,
    input  ready
  );

  modport sink (
    input  valid, day_first, month_first, year_first,
    input  day_second, month_second, year_second,
    output ready
  );
endinterface

interface ddd_out_if;
  import ddd_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] day_count;
  logic [1:0]         order;
  logic               first_valid;
  logic               second_valid;

  modport source (
    output valid, day_count, order, first_valid, second_valid,
    input  ready
  );

  modport sink (
    input  valid, day_count, order, first_valid, second_valid,
    output ready
  );
endinterface
`default_nettype wire

// ===== rtl/ddd_serial.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Serial day number pipeline
// Four stages: century split, leap and validity, partial sums, final sum.
// ----------------------------------------------------------------------------
module ddd_serial (
  input  wire logic                           clk,
  input  wire logic [ddd_pkg::STAGES-1:0]     en,
  input  wire logic [ddd_pkg::DAY_BITS-1:0]   day,
  input  wire logic [ddd_pkg::MONTH_BITS-1:0] month,
  input  wire logic [ddd_pkg::YEAR_BITS-1:0]  year,
  output logic      [ddd_pkg::SER_W-1:0]      serial,
  output logic                                date_ok
);
  import ddd_pkg::*;

  // stage 1
  logic [PROD_W-1:0]     prod_nxt;
  logic [YEAR_BITS-1:0]  y_s1_r;
  logic [MONTH_BITS-1:0] m_s1_r;
  logic [DAY_BITS-1:0]   d_s1_r;
  logic [QUO_W-1:0]      qe_s1_r;

  // stage 2
  logic [YEAR_BITS-1:0]  hund_nxt;
  logic [YEAR_BITS-1:0]  rdiff_nxt;
  logic [REM_W-1:0]      rem_nxt;
  logic                  fix_nxt;
  logic [QUO_W-1:0]      q_nxt;
  logic [REM_W-1:0]      r_nxt;
  logic                  rnz_nxt;
  logic                  leap_nxt;
  logic [DAY_BITS-1:0]   mlen_nxt;
  logic                  ok_nxt;
  logic [YEAR_BITS-1:0]  y_s2_r;
  logic [MONTH_BITS-1:0] m_s2_r;
  logic [DAY_BITS-1:0]   d_s2_r;
  logic [QUO_W-1:0]      q_s2_r;
  logic                  rnz_s2_r;
  logic                  leap_s2_r;
  logic                  ok_s2_r;

  // stage 3
  logic [YEAR_BITS:0]    y3_nxt;
  logic [LEAPS_W-1:0]    c4_nxt;
  logic [LEAPS_W-1:0]    c100_nxt;
  logic [LEAPS_W-1:0]    c400_nxt;
  logic [LEAPS_W-1:0]    leaps_nxt;
  logic [SER_W-1:0]      y365_nxt;
  logic                  adj_nxt;
  logic [OFFS_W-1:0]     offs_nxt;
  logic [SER_W-1:0]      y365_s3_r;
  logic [LEAPS_W-1:0]    leaps_s3_r;
  logic [OFFS_W-1:0]     offs_s3_r;
  logic                  ok_s3_r;

  // stage 4
  logic [SER_W-1:0]      serial_nxt;
  logic [SER_W-1:0]      serial_s4_r;
  logic                  ok_s4_r;

  // year / 100 estimate, short by at most one
  assign prod_nxt = PROD_W'(year) * PROD_W'(RECIP_100);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      y_s1_r  <= year;
      m_s1_r  <= month;
      d_s1_r  <= day;
      qe_s1_r <= prod_nxt[RECIP_SHIFT +: QUO_W];
    end
  end

  // correct the quotient, then leap year and date check
  always_comb begin
    hund_nxt  = YEAR_BITS'(qe_s1_r) * YEAR_BITS'(CENTURY);
    rdiff_nxt = y_s1_r - hund_nxt;
    rem_nxt   = rdiff_nxt[REM_W-1:0];
    fix_nxt   = (rem_nxt >= REM_W'(CENTURY));
    q_nxt     = fix_nxt ? (qe_s1_r + QUO_W'(1)) : qe_s1_r;
    r_nxt     = fix_nxt ? (rem_nxt - REM_W'(CENTURY)) : rem_nxt;
    rnz_nxt   = (r_nxt != '0);
    // divisible by 400 means a whole century and a quotient divisible by 4
    leap_nxt  = ((y_s1_r[1:0] == 2'b00) && rnz_nxt) ||
                (!rnz_nxt && (q_nxt[1:0] == 2'b00));
    mlen_nxt  = month_len(m_s1_r, leap_nxt);
    ok_nxt    = (m_s1_r >= MONTH_JAN) && (m_s1_r <= MONTH_DEC) &&
                (d_s1_r != '0) && (d_s1_r <= mlen_nxt);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      y_s2_r    <= y_s1_r;
      m_s2_r    <= m_s1_r;
      d_s2_r    <= d_s1_r;
      q_s2_r    <= q_nxt;
      rnz_s2_r  <= rnz_nxt;
      leap_s2_r <= leap_nxt;
      ok_s2_r   <= ok_nxt;
    end
  end

  // leap days in the years before this one, and day of the year
  always_comb begin
    y3_nxt    = {1'b0, y_s2_r} + (YEAR_BITS + 1)'(3);
    c4_nxt    = y3_nxt[YEAR_BITS:2];
    c100_nxt  = LEAPS_W'(q_s2_r) + LEAPS_W'(rnz_s2_r);
    c400_nxt  = LEAPS_W'(q_s2_r >> 2) +
                LEAPS_W'(rnz_s2_r || (q_s2_r[1:0] != 2'b00));
    leaps_nxt = c4_nxt - c100_nxt + c400_nxt;
    y365_nxt  = SER_W'(y_s2_r) * SER_W'(DAYS_YEAR);
    adj_nxt   = leap_s2_r && (m_s2_r > MONTH_FEB);
    offs_nxt  = days_before(m_s2_r) + OFFS_W'(d_s2_r) - OFFS_W'(1) + OFFS_W'(adj_nxt);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      y365_s3_r  <= y365_nxt;
      leaps_s3_r <= leaps_nxt;
      offs_s3_r  <= offs_nxt;
      ok_s3_r    <= ok_s2_r;
    end
  end

  assign serial_nxt = y365_s3_r + SER_W'(leaps_s3_r) + SER_W'(offs_s3_r);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      serial_s4_r <= serial_nxt;
      ok_s4_r     <= ok_s3_r;
    end
  end

  assign serial  = serial_s4_r;
  assign date_ok = ok_s4_r;

endmodule
`default_nettype wire

// ===== rtl/date_day_difference.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Date day difference
// Day count, order and validity of two Gregorian dates.
// ----------------------------------------------------------------------------
// The block takes one date pair word per cycle while its output is not stalled
// and returns one result word per pair: four stages turn each date into a
// serial day number (century split, leap and validity check, partial sums,
// final sum) and the output register forms the saturated absolute difference.
// Each stage holds its own valid bit and moves whenever the stage after it is
// free, so a stalled output only backs up the words behind it and bubbles are
// filled. The day count is zero when either date is invalid; order compares
// the raw fields (year, then month, then day) for any input.
module date_day_difference (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ddd_in_if.sink     in_ch,
  ddd_out_if.source  out_ch
);
  import ddd_pkg::*;

  localparam int KEY_W = YEAR_BITS + MONTH_BITS + DAY_BITS;

  logic [STAGES:0]      en;
  logic [STAGES-1:0]    v_nxt;
  logic [STAGES-1:0]    v_r;
  order_t               ord_nxt;
  order_t               ord_r [STAGES];
  logic [KEY_W-1:0]     key_a;
  logic [KEY_W-1:0]     key_b;

  logic [SER_W-1:0]     serial_a;
  logic [SER_W-1:0]     serial_b;
  logic                 ok_a;
  logic                 ok_b;

  logic [SER_W-1:0]     diff_nxt;
  logic [DIFF_W-1:0]    diff_ext;
  logic [COUNT_W-1:0]   count_nxt;

  logic                 out_valid_r;
  logic [COUNT_W-1:0]   count_r;
  order_t               ord_out_r;
  logic                 fv_r;
  logic                 sv_r;

  // a stage moves when it is empty or the stage after it moves
  always_comb begin
    en[STAGES] = !out_valid_r || out_ch.ready;
    for (int k = STAGES - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    v_nxt[0] = in_ch.valid;
    for (int k = 1; k < STAGES; k++) begin
      v_nxt[k] = v_r[k-1];
    end
  end

  assign in_ch.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      for (int k = 0; k < STAGES; k++) begin
        if (en[k]) begin
          v_r[k] <= v_nxt[k];
        end
      end
      if (en[STAGES]) begin
        out_valid_r <= v_r[STAGES-1];
      end
    end
  end

  // order on raw fields
  always_comb begin
    key_a = {in_ch.year_first, in_ch.month_first, in_ch.day_first};
    key_b = {in_ch.year_second, in_ch.month_second, in_ch.day_second};
    if (key_a == key_b) begin
      ord_nxt = ORD_EQUAL;
    end else if (key_a > key_b) begin
      ord_nxt = ORD_FIRST_LATER;
    end else begin
      ord_nxt = ORD_FIRST_EARLIER;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ord_r[0] <= ord_nxt;
    end
    for (int k = 1; k < STAGES; k++) begin
      if (en[k]) begin
        ord_r[k] <= ord_r[k-1];
      end
    end
  end

  ddd_serial u_serial_first (
    .clk     (clk),
    .en      (en[STAGES-1:0]),
    .day     (in_ch.day_first),
    .month   (in_ch.month_first),
    .year    (in_ch.year_first),
    .serial  (serial_a),
    .date_ok (ok_a)
  );

  ddd_serial u_serial_second (
    .clk     (clk),
    .en      (en[STAGES-1:0]),
    .day     (in_ch.day_second),
    .month   (in_ch.month_second),
    .year    (in_ch.year_second),
    .serial  (serial_b),
    .date_ok (ok_b)
  );

  // absolute difference, saturate, drop when either date is invalid
  always_comb begin
    diff_nxt = (serial_a >= serial_b) ? (serial_a - serial_b) : (serial_b - serial_a);
    diff_ext = DIFF_W'(diff_nxt);
    if (!(ok_a && ok_b)) begin
      count_nxt = '0;
    end else if (diff_ext > DIFF_W'(COUNT_MAX)) begin
      count_nxt = COUNT_MAX;
    end else begin
      count_nxt = diff_ext[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[STAGES]) begin
      count_r   <= count_nxt;
      ord_out_r <= ord_r[STAGES-1];
      fv_r      <= ok_a;
      sv_r      <= ok_b;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.day_count    = count_r;
  assign out_ch.order        = ord_out_r;
  assign out_ch.first_valid  = fv_r;
  assign out_ch.second_valid = sv_r;

  // invalid dates never carry a day count
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !(out_ch.first_valid && out_ch.second_valid) |-> out_ch.day_count == '0)
    else $error("day count nonzero for an invalid date");

  // equal valid dates are zero days apart; catches order and serial misalignment
  a_equal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.first_valid && out_ch.second_valid &&
    (out_ch.order == ORD_EQUAL) |-> out_ch.day_count == '0)
    else $error("equal dates with nonzero day count");

  // input backs up only behind a stalled result
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid && !out_ch.ready)
    else $error("input stalled while output free");

endmodule
`default_nettype wire
